[src/hsv2rgb_pkg.sv]
// Shared types and constants for the HSV to RGB converter.
package hsv2rgb_pkg;

  // Input request: hue in degrees, saturation and value in percent.
  typedef struct packed {
    logic signed [10:0] hue;
    logic [6:0]         saturation;
    logic [6:0]         brightness_value;
  } in_t;

  // Result: 8-bit color channels.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  // Six 60-degree hue bands.
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PROD_W  = 14;  // v*s and v*100 stay at or below 10000
  localparam int unsigned SUM_W   = 20;  // channel sums stay at or below 600000
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NUM_CH  = 3;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Chroma, value and hue distance after the front end.
  typedef struct packed {
    logic [PROD_W-1:0] chroma;
    logic [PROD_W-1:0] v100;
    logic [5:0]        hdist;
    sector_t           sector;
  } front_t;

  // Scaled channel sums on a denominator of 600000; index 0 red, 1 green, 2 blue.
  typedef struct packed {
    logic [NUM_CH-1:0][SUM_W-1:0] ch;
  } mix_t;

endpackage

[src/hsv2rgb_front.sv]
// Hue wrap, percent clamp, chroma product and hue sector/distance (two stages).
module hsv2rgb_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  hsv2rgb_pkg::in_t      in_data,
  output logic                  out_vld,
  output hsv2rgb_pkg::front_t   out_data
);

  // Stage 1: wrap hue into 0..359, clamp percentages.
  logic [11:0] hx;
  logic [23:0] hq_prod;
  logic [3:0]  hq;
  logic [11:0] hmod_full;
  logic [8:0]  hmod_nxt;
  logic [6:0]  s_nxt;
  logic [6:0]  v_nxt;

  logic        vld1_r;
  logic [8:0]  hmod_r;
  logic [6:0]  s_r;
  logic [6:0]  v_r;

  // Bias by three turns so the value is positive, then divide by 360 via reciprocal.
  assign hx        = {in_data.hue[10], in_data.hue} + 12'd1080;
  assign hq_prod   = 24'(hx) * 24'd2913;
  assign hq        = hq_prod[23:20];
  assign hmod_full = hx - 12'(hq) * 12'd360;
  assign hmod_nxt  = hmod_full[8:0];

  assign s_nxt = (in_data.saturation > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX
                                                             : in_data.saturation;
  assign v_nxt = (in_data.brightness_value > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX
                                                                   : in_data.brightness_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    hmod_r <= hmod_nxt;
    s_r    <= s_nxt;
    v_r    <= v_nxt;
  end

  // Stage 2: sector, distance to the nearest multiple of 120 degrees, chroma and scaled value.
  hsv2rgb_pkg::sector_t sec_nxt;
  logic [8:0]           hm120;
  logic [6:0]           dev;
  logic [5:0]           dist_nxt;
  hsv2rgb_pkg::front_t  front_nxt;
  logic                 vld2_r;
  hsv2rgb_pkg::front_t  front_r;

  always_comb begin
    if (hmod_r < 9'd60) begin
      sec_nxt = hsv2rgb_pkg::SEC_RY;
    end else if (hmod_r < 9'd120) begin
      sec_nxt = hsv2rgb_pkg::SEC_YG;
    end else if (hmod_r < 9'd180) begin
      sec_nxt = hsv2rgb_pkg::SEC_GC;
    end else if (hmod_r < 9'd240) begin
      sec_nxt = hsv2rgb_pkg::SEC_CB;
    end else if (hmod_r < 9'd300) begin
      sec_nxt = hsv2rgb_pkg::SEC_BM;
    end else begin
      sec_nxt = hsv2rgb_pkg::SEC_MR;
    end

    if (hmod_r < 9'd120) begin
      hm120 = hmod_r;
    end else if (hmod_r < 9'd240) begin
      hm120 = hmod_r - 9'd120;
    end else begin
      hm120 = hmod_r - 9'd240;
    end

    dev      = (hm120[6:0] >= 7'd60) ? (hm120[6:0] - 7'd60) : (7'd60 - hm120[6:0]);
    dist_nxt = 6'(7'd60 - dev);

    front_nxt.chroma = 14'(v_r) * 14'(s_r);
    front_nxt.v100   = 14'(v_r) * 14'd100;
    front_nxt.hdist  = dist_nxt;
    front_nxt.sector = sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
  end

  assign out_vld  = vld2_r;
  assign out_data = front_r;

endmodule

[src/hsv2rgb_mix.sv]
// Chroma, secondary and offset terms, then per-channel placement (two stages).
module hsv2rgb_mix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  hsv2rgb_pkg::front_t  in_data,
  output logic                 out_vld,
  output hsv2rgb_pkg::mix_t    out_data
);

  localparam int unsigned SW = hsv2rgb_pkg::SUM_W;

  // Stage 3: terms on a common denominator of 600000.
  logic                 vld3_r;
  logic [SW-1:0]        cc_r;
  logic [SW-1:0]        xx_r;
  logic [SW-1:0]        mm_r;
  hsv2rgb_pkg::sector_t sec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    cc_r  <= SW'(in_data.chroma) * SW'(60);
    xx_r  <= SW'(in_data.chroma) * SW'(in_data.hdist);
    mm_r  <= SW'(in_data.v100 - in_data.chroma) * SW'(60);
    sec_r <= in_data.sector;
  end

  // Stage 4: place chroma and secondary by sector, add the offset.
  hsv2rgb_pkg::mix_t mix_nxt;
  hsv2rgb_pkg::mix_t mix_r;
  logic              vld4_r;

  always_comb begin
    mix_nxt.ch[0] = mm_r;
    mix_nxt.ch[1] = mm_r;
    mix_nxt.ch[2] = mm_r;
    unique case (sec_r)
      hsv2rgb_pkg::SEC_RY: begin
        mix_nxt.ch[0] = cc_r + mm_r;
        mix_nxt.ch[1] = xx_r + mm_r;
      end
      hsv2rgb_pkg::SEC_YG: begin
        mix_nxt.ch[0] = xx_r + mm_r;
        mix_nxt.ch[1] = cc_r + mm_r;
      end
      hsv2rgb_pkg::SEC_GC: begin
        mix_nxt.ch[1] = cc_r + mm_r;
        mix_nxt.ch[2] = xx_r + mm_r;
      end
      hsv2rgb_pkg::SEC_CB: begin
        mix_nxt.ch[1] = xx_r + mm_r;
        mix_nxt.ch[2] = cc_r + mm_r;
      end
      hsv2rgb_pkg::SEC_BM: begin
        mix_nxt.ch[0] = xx_r + mm_r;
        mix_nxt.ch[2] = cc_r + mm_r;
      end
      hsv2rgb_pkg::SEC_MR: begin
        mix_nxt.ch[0] = cc_r + mm_r;
        mix_nxt.ch[2] = xx_r + mm_r;
      end
      default: begin
        mix_nxt.ch[0] = mm_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    mix_r <= mix_nxt;
  end

  assign out_vld  = vld4_r;
  assign out_data = mix_r;

endmodule

[src/hsv2rgb_scale.sv]
// Scale each channel sum by 255/600000 with floor, in three stages.
module hsv2rgb_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  hsv2rgb_pkg::mix_t  in_data,
  output logic               out_vld,
  output hsv2rgb_pkg::out_t  out_data
);

  localparam int unsigned NCH = hsv2rgb_pkg::NUM_CH;
  localparam int unsigned SW  = hsv2rgb_pkg::SUM_W;
  localparam int unsigned ZW  = 18;  // (sum*17)>>6 stays below 2^18
  localparam int unsigned PW  = 29;  // ZW + 11 bits of reciprocal
  localparam int unsigned QW  = 9;

  // floor(sum*255/600000) = floor(floor(sum*17/64)/625)
  logic               vld5_r;
  logic               vld6_r;
  logic               vld7_r;
  logic [ZW-1:0]      z_r    [NCH];
  logic [ZW-1:0]      zz_r   [NCH];
  logic [PW-1:0]      p_r    [NCH];
  logic [ZW+5:0]      y17    [NCH];
  logic [QW-1:0]      q0     [NCH];
  logic [ZW:0]        rem    [NCH];
  logic [QW:0]        q      [NCH];
  logic [7:0]         ch_nxt [NCH];
  logic [7:0]         ch_r   [NCH];

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      y17[i]    = (ZW+6)'(in_data.ch[i]) * (ZW+6)'(17);
      q0[i]     = p_r[i][PW-1:PW-QW];
      rem[i]    = (ZW+1)'(zz_r[i]) - (ZW+1)'(q0[i]) * (ZW+1)'(625);
      q[i]      = (rem[i] >= (ZW+1)'(625)) ? ((QW+1)'(q0[i]) + (QW+1)'(1))
                                           : (QW+1)'(q0[i]);
      ch_nxt[i] = (q[i] > (QW+1)'(255)) ? 8'hFF : q[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld5_r <= in_vld;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NCH; i++) begin
      z_r[i]  <= y17[i][ZW+5:6];
      p_r[i]  <= PW'(z_r[i]) * PW'(1677);
      zz_r[i] <= z_r[i];
      ch_r[i] <= ch_nxt[i];
    end
  end

  assign out_vld        = vld7_r;
  assign out_data.red   = ch_r[0];
  assign out_data.green = ch_r[1];
  assign out_data.blue  = ch_r[2];

endmodule

[src/hsv_to_rgb_converter_top.sv]
// Top level of the HSV to RGB converter: pipeline wiring and checks.
//
// Usage:
//   Input channel: drive a request on in_data (hue in signed degrees,
//   saturation and value in percent) and pulse start. The request is taken
//   at any rising edge where start is high and busy is low; busy is never
//   raised, so a request may arrive on every clock.
//   Result channel: out_data carries red, green and blue for exactly one
//   cycle, flagged by out_valid. The receiver cannot stall; capture it then.
//   Throughput: one request per clock, fixed by the seven-stage pipeline
//   (two front-end stages, two mixing stages, three scaling stages).
//   Results leave in request order.
//   Reset: synchronous, active low. It clears every stage's valid flag, so
//   requests in flight are dropped and no result appears until new ones
//   enter; datapath registers are left as they are.
module hsv_to_rgb_converter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hsv2rgb_pkg::in_t   in_data,
  output logic               out_valid,
  output hsv2rgb_pkg::out_t  out_data
);

  logic                 in_acc;
  logic                 front_vld;
  hsv2rgb_pkg::front_t  front_data;
  logic                 mix_vld;
  hsv2rgb_pkg::mix_t    mix_data;

  // Never hold off a request: every stage advances each clock.
  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  // Wrap hue, clamp percentages, form chroma and hue distance.
  hsv2rgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_acc),
    .in_data  (in_data),
    .out_vld  (front_vld),
    .out_data (front_data)
  );

  // Build the chroma, secondary and offset terms and place them per channel.
  hsv2rgb_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (front_vld),
    .in_data  (front_data),
    .out_vld  (mix_vld),
    .out_data (mix_data)
  );

  // Scale each channel to 8 bits with floor.
  hsv2rgb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (mix_vld),
    .in_data  (mix_data),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  // Every accepted request yields its result, flagged by out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##7 out_valid)
    else $error("result missing seven cycles after request");

  // A gray request (zero saturation) gives three equal channels.
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.saturation == 7'd0) |-> ##7
      (out_data.red == out_data.green && out_data.green == out_data.blue))
    else $error("zero saturation gave unequal channels");

  // Zero value gives black.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.brightness_value == 7'd0) |-> ##7
      (out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0))
    else $error("zero value gave a nonblack result");

  // Full value and saturation at hue zero is pure red.
  a_red: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.hue == 11'sd0 && in_data.saturation == 7'd100 &&
     in_data.brightness_value == 7'd100) |-> ##7
      (out_data.red == 8'd255 && out_data.green == 8'd0 && out_data.blue == 8'd0))
    else $error("hue zero at full saturation is not pure red");

endmodule
